### rtl/line_segment_clipper_top_macros.svh
// assertion macros shared by the checker
`ifndef LINE_SEGMENT_CLIPPER_TOP_MACROS_SVH
`define LINE_SEGMENT_CLIPPER_TOP_MACROS_SVH

// clocked assertion, held off during reset
`define LSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define LSC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/lsc_pkg.sv
// shared types and constants of the line segment clipper
package lsc_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned DivW   = 76;
  localparam int unsigned DivCntW = $clog2(DivW);

  // outcode bit positions
  localparam int unsigned OcLeft   = 0;
  localparam int unsigned OcRight  = 1;
  localparam int unsigned OcBottom = 2;
  localparam int unsigned OcTop    = 3;

  // register indexes
  localparam logic [1:0] RegAx = 2'd0;
  localparam logic [1:0] RegAy = 2'd1;
  localparam logic [1:0] RegBx = 2'd2;
  localparam logic [1:0] RegBy = 2'd3;

  // datapath operations
  localparam logic [3:0] OpNone   = 4'd0;
  localparam logic [3:0] OpLoad   = 4'd1;
  localparam logic [3:0] OpDivM   = 4'd2;
  localparam logic [3:0] OpTakeM  = 4'd3;
  localparam logic [3:0] OpMulLo  = 4'd4;
  localparam logic [3:0] OpMulHi  = 4'd5;
  localparam logic [3:0] OpTakeN  = 4'd6;
  localparam logic [3:0] OpTbKeep = 4'd7;
  localparam logic [3:0] OpDivX   = 4'd8;
  localparam logic [3:0] OpTakeX  = 4'd9;
  localparam logic [3:0] OpReject = 4'd10;
  localparam logic [3:0] OpTakeY  = 4'd11;
  localparam logic [3:0] OpOut    = 4'd12;

  typedef struct packed {
    logic [3:0] op;
    logic       sel_edge;
    logic       vis;
  } cmd_t;

  typedef struct packed {
    logic accept;
    logic reject;
    logic tb;
    logic vert;
    logic m_zero;
    logic div_done;
  } stat_t;

endpackage

### rtl/lsc_div.sv
// iterative restoring divider, one quotient bit per cycle
module lsc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [lsc_pkg::DivW-1:0]    dividend_i,
  input  logic [63:0]                 divisor_i,
  input  logic                        neg_i,
  output logic                        done_o,
  output logic signed [63:0]          q_o,
  output logic                        fit64_o,
  output logic                        fit32_o
);

  logic                          busy_q, busy_d;
  logic [lsc_pkg::DivCntW-1:0]   cnt_q, cnt_d;
  logic [63:0]                   rem_q, rem_d;
  logic [lsc_pkg::DivW-1:0]      quo_q, quo_d;
  logic [63:0]                   div_q, div_d;
  logic                          neg_q, neg_d;
  logic                          done_q, done_d;
  logic [64:0]                   rem_s;
  logic                          ge;
  logic [lsc_pkg::DivW-64:0]     hi64;
  logic [lsc_pkg::DivW-32:0]     hi32;

  always_comb begin
    rem_s  = {rem_q, quo_q[lsc_pkg::DivW-1]};
    ge     = rem_s >= {1'b0, div_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      div_d  = divisor_i;
      neg_d  = neg_i;
    end else if (busy_q) begin
      rem_d = ge ? 64'(rem_s - {1'b0, div_q}) : rem_s[63:0];
      quo_d = {quo_q[lsc_pkg::DivW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == lsc_pkg::DivCntW'(lsc_pkg::DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
    neg_q <= neg_d;
  end

  // range checks on the signed quotient
  assign hi64    = quo_q[lsc_pkg::DivW-1:63];
  assign hi32    = quo_q[lsc_pkg::DivW-1:31];
  assign fit64_o = (hi64 == '0) ||
                   (neg_q && (hi64 == (lsc_pkg::DivW-63)'(1)) && (quo_q[62:0] == '0));
  assign fit32_o = (hi32 == '0) ||
                   (neg_q && (hi32 == (lsc_pkg::DivW-31)'(1)) && (quo_q[30:0] == '0));
  assign q_o     = neg_q ? -$signed(quo_q[63:0]) : $signed(quo_q[63:0]);
  assign done_o  = done_q;

endmodule

### rtl/lsc_datapath.sv
// endpoint, slope and intercept registers with the shared divider and multiplier
module lsc_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  input  logic signed [31:0]   start_x_i,
  input  logic signed [31:0]   start_y_i,
  input  logic signed [31:0]   end_x_i,
  input  logic signed [31:0]   end_y_i,
  input  lsc_pkg::cmd_t        cmd_i,
  output lsc_pkg::stat_t       stat_o,
  output logic                 visible_o,
  output logic signed [31:0]   out_start_x_o,
  output logic signed [31:0]   out_start_y_o,
  output logic signed [31:0]   out_end_x_o,
  output logic signed [31:0]   out_end_y_o,
  output logic                 start_moved_o,
  output logic                 end_moved_o
);

  logic signed [31:0] ax_q, ay_q, bx_q, by_q;
  logic signed [31:0] xmin, xmax, ymin, ymax;
  logic signed [31:0] px_q [2];
  logic signed [31:0] py_q [2];
  logic signed [32:0] dx_q, dy_q;
  logic signed [63:0] m_q, n_q;
  logic [95:0]        acc_q;
  logic               pneg_q;
  logic               vert_q;
  logic [1:0]         moved_q;

  logic [3:0]         c0, c1, c;
  logic               k;
  logic signed [31:0] e_x, e_y, mul_b;
  logic [31:0]        b_mag;
  logic [63:0]        m_mag;
  logic [32:0]        dx_mag, dy_mag;
  logic [95:0]        t_mag;
  logic signed [95:0] t_s, n_full, s_lr, s_mag;
  logic [95:0]        qy_mag;
  logic signed [31:0] y_sat;
  logic signed [75:0] num;
  logic [75:0]        num_mag;

  logic                 div_start, div_neg, div_done, fit64, fit32;
  logic [lsc_pkg::DivW-1:0] div_dividend;
  logic [63:0]          div_divisor;
  logic signed [63:0]   div_q;

  function automatic logic [3:0] outcode(input logic signed [31:0] x, input logic signed [31:0] y,
                                         input logic signed [31:0] x0, input logic signed [31:0] x1,
                                         input logic signed [31:0] y0, input logic signed [31:0] y1);
    logic [3:0] r;
    r = '0;
    r[lsc_pkg::OcLeft]   = x < x0;
    r[lsc_pkg::OcRight]  = x > x1;
    r[lsc_pkg::OcTop]    = y < y0;
    r[lsc_pkg::OcBottom] = y > y1;
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ax_q <= '0;
      ay_q <= '0;
      bx_q <= '0;
      by_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lsc_pkg::RegAx: ax_q <= cfg_data_i;
        lsc_pkg::RegAy: ay_q <= cfg_data_i;
        lsc_pkg::RegBx: bx_q <= cfg_data_i;
        lsc_pkg::RegBy: by_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign xmin = (ax_q > bx_q) ? bx_q : ax_q;
  assign xmax = (ax_q > bx_q) ? ax_q : bx_q;
  assign ymin = (ay_q > by_q) ? by_q : ay_q;
  assign ymax = (ay_q > by_q) ? ay_q : by_q;

  // pick the endpoint to clip and its edge
  always_comb begin
    c0  = outcode(px_q[0], py_q[0], xmin, xmax, ymin, ymax);
    c1  = outcode(px_q[1], py_q[1], xmin, xmax, ymin, ymax);
    k   = (c0 == '0);
    c   = k ? c1 : c0;
    e_y = c[lsc_pkg::OcTop] ? ymin : ymax;
    e_x = c[lsc_pkg::OcLeft] ? xmin : xmax;
  end

  // magnitude multiply of 64x32 in two halves of 32x32 each
  assign mul_b  = cmd_i.sel_edge ? e_x : px_q[0];
  assign b_mag  = mul_b[31] ? 32'(-mul_b) : 32'(mul_b);
  assign m_mag  = m_q[63] ? 64'(-m_q) : 64'(m_q);
  assign t_mag  = acc_q >> 8;
  assign t_s    = pneg_q ? -$signed(t_mag) : $signed(t_mag);
  assign n_full = (96'(py_q[0]) <<< 24) - t_s;
  assign s_lr   = t_s + 96'(n_q);
  assign s_mag  = s_lr[95] ? -s_lr : s_lr;
  assign qy_mag = 96'(s_mag) >> 24;

  always_comb begin
    if (!s_lr[95] && (qy_mag > 96'h7FFF_FFFF)) begin
      y_sat = 32'sh7FFF_FFFF;
    end else if (s_lr[95] && (qy_mag > 96'h8000_0000)) begin
      y_sat = 32'sh8000_0000;
    end else begin
      y_sat = s_lr[95] ? 32'(-qy_mag) : 32'(qy_mag);
    end
  end

  // x on a top or bottom edge: ((e << 24) - n) << 8, over m
  assign num     = (76'(e_y) <<< 32) - (76'(n_q) <<< 8);
  assign num_mag = num[75] ? 76'(-num) : 76'(num);
  assign dx_mag  = dx_q[32] ? 33'(-dx_q) : 33'(dx_q);
  assign dy_mag  = dy_q[32] ? 33'(-dy_q) : 33'(dy_q);

  always_comb begin
    div_start    = 1'b0;
    div_dividend = 76'(dy_mag) << 32;
    div_divisor  = 64'(dx_mag);
    div_neg      = dy_q[32] ^ dx_q[32];
    if (cmd_i.op == lsc_pkg::OpDivM) begin
      div_start = 1'b1;
    end else if (cmd_i.op == lsc_pkg::OpDivX) begin
      div_start    = 1'b1;
      div_dividend = num_mag;
      div_divisor  = m_mag;
      div_neg      = num[75] ^ m_q[63];
    end
  end

  lsc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .neg_i      (div_neg),
    .done_o     (div_done),
    .q_o        (div_q),
    .fit64_o    (fit64),
    .fit32_o    (fit32)
  );

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      lsc_pkg::OpLoad: begin
        px_q[0] <= start_x_i;
        py_q[0] <= start_y_i;
        px_q[1] <= end_x_i;
        py_q[1] <= end_y_i;
        dx_q    <= 33'(end_x_i) - 33'(start_x_i);
        dy_q    <= 33'(end_y_i) - 33'(start_y_i);
        vert_q  <= (end_x_i == start_x_i);
        m_q     <= '0;
        n_q     <= '0;
        moved_q <= '0;
      end
      lsc_pkg::OpTakeM: begin
        if (fit64) m_q <= div_q;
        else vert_q <= 1'b1;
      end
      lsc_pkg::OpMulLo: begin
        acc_q  <= 96'(m_mag[31:0] * b_mag);
        pneg_q <= m_q[63] ^ mul_b[31];
      end
      lsc_pkg::OpMulHi: begin
        acc_q <= acc_q + (96'(m_mag[63:32] * b_mag) << 32);
      end
      lsc_pkg::OpTakeN: begin
        if (n_full[95:63] == '0 || n_full[95:63] == '1) n_q <= 64'(n_full);
        else vert_q <= 1'b1;
      end
      lsc_pkg::OpTbKeep: begin
        moved_q[k] <= 1'b1;
        vert_q     <= 1'b1;
        py_q[k]    <= e_y;
      end
      lsc_pkg::OpDivX: begin
        moved_q[k] <= 1'b1;
      end
      lsc_pkg::OpTakeX: begin
        if (fit32) px_q[k] <= 32'(div_q);
        else vert_q <= 1'b1;
        py_q[k] <= e_y;
      end
      lsc_pkg::OpReject: begin
        moved_q[k] <= 1'b1;
      end
      lsc_pkg::OpTakeY: begin
        moved_q[k] <= 1'b1;
        px_q[k]    <= e_x;
        py_q[k]    <= y_sat;
      end
      lsc_pkg::OpOut: begin
        visible_o     <= cmd_i.vis;
        out_start_x_o <= px_q[0];
        out_start_y_o <= py_q[0];
        out_end_x_o   <= px_q[1];
        out_end_y_o   <= py_q[1];
        start_moved_o <= moved_q[0];
        end_moved_o   <= moved_q[1];
      end
      default: ;
    endcase
  end

  assign stat_o.accept   = (c0 | c1) == '0;
  assign stat_o.reject   = (c0 & c1) != '0;
  assign stat_o.tb       = c[lsc_pkg::OcTop] | c[lsc_pkg::OcBottom];
  assign stat_o.vert     = vert_q;
  assign stat_o.m_zero   = (m_q == '0);
  assign stat_o.div_done = div_done;

endmodule

### rtl/lsc_ctrl.sv
// sequencer for slope, intercept and outcode passes
module lsc_ctrl #(
  parameter int unsigned MAX_PASSES = 5
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  lsc_pkg::stat_t  stat_i,
  output lsc_pkg::cmd_t   cmd_o
);

  localparam int unsigned PassW = $clog2(MAX_PASSES + 1);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StInit = 4'd1;
  localparam logic [3:0] StWdm  = 4'd2;
  localparam logic [3:0] StMs0  = 4'd3;
  localparam logic [3:0] StMs1  = 4'd4;
  localparam logic [3:0] StTn   = 4'd5;
  localparam logic [3:0] StPass = 4'd6;
  localparam logic [3:0] StWdx  = 4'd7;
  localparam logic [3:0] StLr1  = 4'd8;
  localparam logic [3:0] StLr2  = 4'd9;
  localparam logic [3:0] StFin  = 4'd10;

  logic [3:0]       state_q, state_d;
  logic [PassW-1:0] pass_q, pass_d;
  logic             vis_q, vis_d;
  logic             oval_q, oval_d;

  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    vis_d   = vis_q;
    oval_d  = oval_q & ~out_ready_i;
    cmd_o   = '{op: lsc_pkg::OpNone, sel_edge: 1'b0, vis: vis_q};
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.op = lsc_pkg::OpLoad;
          pass_d   = '0;
          state_d  = StInit;
        end
      end
      StInit: begin
        if (stat_i.vert) begin
          state_d = StPass;
        end else begin
          cmd_o.op = lsc_pkg::OpDivM;
          state_d  = StWdm;
        end
      end
      StWdm: begin
        if (stat_i.div_done) begin
          cmd_o.op = lsc_pkg::OpTakeM;
          state_d  = StMs0;
        end
      end
      StMs0: begin
        if (stat_i.vert) begin
          state_d = StPass;
        end else begin
          cmd_o.op = lsc_pkg::OpMulLo;
          state_d  = StMs1;
        end
      end
      StMs1: begin
        cmd_o.op = lsc_pkg::OpMulHi;
        state_d  = StTn;
      end
      StTn: begin
        cmd_o.op = lsc_pkg::OpTakeN;
        state_d  = StPass;
      end
      StPass: begin
        if (pass_q == PassW'(MAX_PASSES)) begin
          vis_d   = 1'b0;
          state_d = StFin;
        end else if (stat_i.accept) begin
          vis_d   = 1'b1;
          state_d = StFin;
        end else if (stat_i.reject) begin
          vis_d   = 1'b0;
          state_d = StFin;
        end else if (stat_i.tb) begin
          if (stat_i.vert || stat_i.m_zero) begin
            cmd_o.op = lsc_pkg::OpTbKeep;
            pass_d   = pass_q + 1'b1;
          end else begin
            cmd_o.op = lsc_pkg::OpDivX;
            state_d  = StWdx;
          end
        end else if (stat_i.vert) begin
          // vertical segment hitting a side edge is dropped
          cmd_o.op = lsc_pkg::OpReject;
          vis_d    = 1'b0;
          state_d  = StFin;
        end else begin
          cmd_o.op       = lsc_pkg::OpMulLo;
          cmd_o.sel_edge = 1'b1;
          state_d        = StLr1;
        end
      end
      StWdx: begin
        if (stat_i.div_done) begin
          cmd_o.op = lsc_pkg::OpTakeX;
          pass_d   = pass_q + 1'b1;
          state_d  = StPass;
        end
      end
      StLr1: begin
        cmd_o.op       = lsc_pkg::OpMulHi;
        cmd_o.sel_edge = 1'b1;
        state_d        = StLr2;
      end
      StLr2: begin
        cmd_o.op = lsc_pkg::OpTakeY;
        pass_d   = pass_q + 1'b1;
        state_d  = StPass;
      end
      StFin: begin
        if (!oval_q || out_ready_i) begin
          cmd_o.op = lsc_pkg::OpOut;
          oval_d   = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pass_q  <= '0;
      vis_q   <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      vis_q   <= vis_d;
      oval_q  <= oval_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = oval_q;

endmodule

### rtl/line_segment_clipper_top.sv
// Cohen-Sutherland clipper for one segment in signed Q23.8 against the rectangle spanned
// by two configured corners. One segment is in work at a time; the result sits in an
// output register so the next segment can be taken while it waits. A segment uses the
// shared one-bit-per-cycle divider (76 quotient bits) for the slope and for each top or
// bottom clip of a sloped segment, so at most 1 + MAX_PASSES divisions; side clips use
// the two-step multiplier instead.
module line_segment_clipper_top #(
  parameter int unsigned MAX_PASSES = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [31:0]  start_x_i,
  input  logic signed [31:0]  start_y_i,
  input  logic signed [31:0]  end_x_i,
  input  logic signed [31:0]  end_y_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                visible_o,
  output logic signed [31:0]  out_start_x_o,
  output logic signed [31:0]  out_start_y_o,
  output logic signed [31:0]  out_end_x_o,
  output logic signed [31:0]  out_end_y_o,
  output logic                start_moved_o,
  output logic                end_moved_o
);

  lsc_pkg::cmd_t  cmd;
  lsc_pkg::stat_t stat;

  lsc_ctrl #(
    .MAX_PASSES (MAX_PASSES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lsc_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .end_x_i       (end_x_i),
    .end_y_i       (end_y_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .visible_o     (visible_o),
    .out_start_x_o (out_start_x_o),
    .out_start_y_o (out_start_y_o),
    .out_end_x_o   (out_end_x_o),
    .out_end_y_o   (out_end_y_o),
    .start_moved_o (start_moved_o),
    .end_moved_o   (end_moved_o)
  );

endmodule

### rtl/lsc_checker.sv
// port-level checks for the clipper, bound to the top level
`include "line_segment_clipper_top_macros.svh"

module lsc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] out_start_x_o
);

  // a taken segment blocks the input until its work is done
  `LSC_ASSERT(a_busy_after_beat, in_valid_i && in_ready_o |=> !in_ready_o, "input ready right after beat")

  // a new result only comes out of work in progress
  `LSC_ASSERT(a_result_from_work, $rose(out_valid_o) |-> $past(!in_ready_o), "result without work")

  `LSC_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_start_x_o), "result dropped or changed")

endmodule

bind line_segment_clipper_top lsc_checker u_lsc_checker (.*);
